/* hw/rtl/sap_pkg.sv */
`default_nettype none

package sap_pkg;

    // Defaults for the top-level parameters.
    localparam int MAX_CHANNELS_DEF = 12;
    localparam int SAMPLE_BITS_DEF  = 24;

    // Fixed field widths.
    localparam int POS_W  = 16;
    localparam int CFG_IW = 3;
    localparam int CFG_DW = 17;
    localparam int CH_W   = 4;

    // Shared iterative units: square root and restoring divider.
    localparam int SQ_RW = 62;
    localparam int SQ_QW = 31;
    localparam int SQ_N  = 31;
    localparam int SQ_CW = 5;
    localparam int DV_NW = 56;
    localparam int DV_DW = 42;
    localparam int DV_CW = 6;

    // Configuration register indexes.
    localparam logic [CFG_IW-1:0] CFG_MODE    = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_LAYOUT  = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_LX      = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_LY      = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_LZ      = 3'd4;
    localparam logic [CFG_IW-1:0] CFG_ROLLOFF = 3'd5;
    localparam logic [CFG_IW-1:0] CFG_MAXDIST = 3'd6;

    // Q2.30 constants.
    localparam logic signed [31:0] ONE30  = 32'sd1073741824;
    localparam logic signed [31:0] HALF30 = 32'sd536870912;
    localparam logic signed [31:0] S45    = 32'sd759250125;

    typedef enum logic [2:0] {
        LAY_AMBI,
        LAY_STEREO,
        LAY_SURR,
        LAY_714,
        LAY_QUAD
    } t_layout;

    typedef struct packed {
        logic signed [31:0] c;
        logic signed [31:0] s;
    } t_coef;

    function automatic t_layout layout_of(input logic mode, input logic [2:0] lay);
        t_layout l;
        if (!mode) begin
            l = LAY_AMBI;
        end else if (lay == 3'd0) begin
            l = LAY_STEREO;
        end else if (lay == 3'd2) begin
            l = LAY_SURR;
        end else if (lay == 3'd3) begin
            l = LAY_714;
        end else begin
            l = LAY_QUAD;
        end
        return l;
    endfunction

    function automatic logic [CH_W-1:0] chan_count(input t_layout l);
        logic [CH_W-1:0] n;
        unique case (l)
            LAY_STEREO: n = 4'd2;
            LAY_SURR:   n = 4'd6;
            LAY_714:    n = 4'd12;
            default:    n = 4'd4;
        endcase
        return n;
    endfunction

    // Eight speakers on a ring, 45 degrees apart, starting at -180 degrees.
    function automatic t_coef ring_coef(input logic [2:0] i);
        t_coef r;
        unique case (i)
            3'd0: r = '{c: -ONE30, s: 32'sd0};
            3'd1: r = '{c: -S45,   s: -S45};
            3'd2: r = '{c: 32'sd0, s: -ONE30};
            3'd3: r = '{c: S45,    s: -S45};
            3'd4: r = '{c: ONE30,  s: 32'sd0};
            3'd5: r = '{c: S45,    s: S45};
            3'd6: r = '{c: 32'sd0, s: ONE30};
            3'd7: r = '{c: -S45,   s: S45};
            default: r = '{c: 32'sd0, s: 32'sd0};
        endcase
        return r;
    endfunction

    // Five-one speaker directions; the LFE slot carries no direction.
    function automatic t_coef surr_coef(input logic [2:0] i);
        t_coef r;
        unique case (i)
            3'd0: r = '{c: 32'sd929940726,  s: -32'sd536779059};
            3'd1: r = '{c: 32'sd929940726,  s: 32'sd536779059};
            3'd2: r = '{c: ONE30,           s: 32'sd0};
            3'd4: r = '{c: -32'sd367178580, s: -32'sd1009010114};
            3'd5: r = '{c: -32'sd367178580, s: 32'sd1009010114};
            default: r = '{c: 32'sd0, s: 32'sd0};
        endcase
        return r;
    endfunction

    function automatic t_coef lobe_coef(input t_layout l, input logic [3:0] k);
        t_coef r;
        unique case (l)
            LAY_SURR: r = surr_coef(k[2:0]);
            LAY_714:  r = ring_coef(k[2:0]);
            LAY_QUAD: begin
                unique case (k[1:0])
                    2'd0: r = ring_coef(3'd3);
                    2'd1: r = ring_coef(3'd5);
                    2'd2: r = ring_coef(3'd7);
                    2'd3: r = ring_coef(3'd1);
                    default: r = ring_coef(3'd3);
                endcase
            end
            default: r = '{c: 32'sd0, s: 32'sd0};
        endcase
        return r;
    endfunction

    // Right shift with rounding half away from zero.
    function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] v,
                                                   input int unsigned sh);
        logic [63:0] m;
        m = v[63] ? 64'(-v) : 64'(v);
        m = (m + (64'd1 << (sh - 1))) >> sh;
        return v[63] ? -$signed(m) : $signed(m);
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/sap_if.sv */
`default_nettype none

// Input item channel.
interface sap_in_if import sap_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic                          func;
    logic signed [POS_W-1:0]       pos_x;
    logic signed [POS_W-1:0]       pos_y;
    logic signed [POS_W-1:0]       pos_z;
    logic signed [SAMPLE_BITS-1:0] sample_in;

    modport source (output valid, func, pos_x, pos_y, pos_z, sample_in, input ready);
    modport sink (input valid, func, pos_x, pos_y, pos_z, sample_in, output ready);
endinterface

// Result item channel.
interface sap_out_if import sap_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic [CH_W-1:0]               channel;
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic                          last;

    modport source (output valid, channel, sample_out, last, input ready);
    modport sink (input valid, channel, sample_out, last, output ready);
endinterface

// Configuration write channel.
interface sap_cfg_if import sap_pkg::*;;
    logic              valid;
    logic              ready;
    logic [CFG_IW-1:0] index;
    logic [CFG_DW-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/spatial_audio_panner.sv */
`default_nettype none

// Spatial audio panner. A position transaction (func 0) stores the emitter
// position and rebuilds the per-channel gain table; so does any write to a
// known configuration register. The rebuild runs on one shared 32x32
// multiplier, a square-root unit that settles one result bit per cycle
// (31 steps) and a restoring divider that settles one quotient bit per cycle
// (56 steps, up to five quotients); neither channel is ready meanwhile. A
// sample transaction (func 1) then produces one scaled sample per channel of
// the current layout, each through S_SMP_MUL, S_SMP_OUT and S_SMP_WAIT, which
// waits while the output side holds ready low, with the final channel marked
// by last. Gains are Q1.15, positions Q8.8.
module spatial_audio_panner import sap_pkg::*; #(
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
    parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sap_cfg_if.sink     i_cfg,
    sap_in_if.sink      i_in,
    sap_out_if.source   o_out
);

    localparam int KW = $clog2(MAX_CHANNELS);
    localparam logic signed [63:0] SMP_MAX = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
    localparam logic signed [63:0] SMP_MIN = -(64'sd1 <<< (SAMPLE_BITS - 1));

    typedef enum logic [4:0] {
        S_IDLE, S_DIFF, S_SQX, S_SQZ, S_SQY, S_SQD,
        S_HQ_GO, S_HQ_WAIT, S_DQ_GO, S_DQ_WAIT,
        S_DV_SETUP, S_DV_WAIT, S_ATT_MUL,
        G_START, G_L1, G_L2, G_L3, G_P1, G_P2, G_H1, G_SQW, G_ATT, G_WR,
        S_SMP_MUL, S_SMP_OUT, S_SMP_WAIT
    } t_state;

    typedef enum logic [2:0] {D_CA, D_SA, D_CE, D_SE, D_ATT} t_dstep;

    t_state r_state;
    t_dstep r_dstep;

    // Configuration and emitter state.
    logic                    r_mode;
    logic [2:0]              r_layout;
    logic signed [POS_W-1:0] r_lx, r_ly, r_lz;
    logic [15:0]             r_rolloff;
    logic [16:0]             r_maxd;
    logic signed [POS_W-1:0] r_ex, r_ey, r_ez;

    // Geometry.
    logic signed [16:0] r_dx, r_dy, r_dz;
    logic [33:0]        r_hsum, r_dsum;
    logic [24:0]        r_hq, r_dq;
    logic signed [31:0] r_ca, r_sa, r_ce, r_se, r_u;
    logic [14:0]        r_att;
    logic signed [63:0] r_prod, r_acc;

    // Gain table and loop control.
    logic signed [15:0] r_gain [MAX_CHANNELS];
    t_layout            r_lay;
    logic [KW-1:0]      r_k;
    logic [CH_W-1:0]    r_n;
    logic signed [SAMPLE_BITS-1:0] r_sample;

    // Output register.
    logic                          r_out_valid;
    logic [CH_W-1:0]               r_out_ch;
    logic signed [SAMPLE_BITS-1:0] r_out_smp;
    logic                          r_out_last;

    // Square-root unit.
    logic [SQ_RW-1:0] r_sq_rad;
    logic [32:0]      r_sq_rem;
    logic [SQ_QW-1:0] r_sq_root;
    logic [SQ_CW-1:0] r_sq_cnt;

    // Divider unit.
    logic [DV_NW-1:0] r_dv_num;
    logic [DV_DW-1:0] r_dv_den;
    logic [DV_DW-1:0] r_dv_rem;
    logic [DV_NW-1:0] r_dv_quo;
    logic [DV_CW-1:0] r_dv_cnt;
    logic             r_dv_neg;

    // Combinational helpers.
    logic               cfg_rdy, in_rdy, k_last;
    logic signed [31:0] mul_a, mul_b, height, lobe_u, p2_u, stereo_u;
    logic signed [63:0] lobe_v, p2_v, gain_v, smp_v, st_diff;
    logic signed [15:0] gain_wr;
    logic signed [SAMPLE_BITS-1:0] smp_val;
    t_coef              coef;
    logic [16:0]        abs_dx, abs_dy, abs_dz;
    logic               sq_go;
    logic [SQ_RW-1:0]   sq_rad;
    logic [34:0]        sq_rem2, sq_trial;
    logic [32:0]        sq_rem_nx;
    logic [SQ_QW-1:0]   sq_root_nx;
    logic               dv_go, dv_neg;
    logic [DV_NW-1:0]   dv_mag;
    logic [DV_DW-1:0]   dv_den;
    logic [DV_DW:0]     dv_rem2;
    logic signed [31:0] dv_qsat, dv_sig;
    logic [14:0]        dv_att;

    assign cfg_rdy = (r_state == S_IDLE);
    assign in_rdy  = (r_state == S_IDLE) && !i_cfg.valid;
    assign i_cfg.ready = cfg_rdy;
    assign i_in.ready  = in_rdy;

    assign o_out.valid      = r_out_valid;
    assign o_out.channel    = r_out_ch;
    assign o_out.sample_out = r_out_smp;
    assign o_out.last       = r_out_last;

    assign k_last = (r_k == KW'(r_n - 4'd1));

    // Datapath decode: shared multiplier operands, rounding and unit launches.
    always_comb begin
        abs_dx = r_dx[16] ? 17'(-r_dx) : 17'(r_dx);
        abs_dy = r_dy[16] ? 17'(-r_dy) : 17'(r_dy);
        abs_dz = r_dz[16] ? 17'(-r_dz) : 17'(r_dz);
        height = (r_se > 32'sd0) ? r_se : 32'sd0;
        coef   = lobe_coef(r_lay, 4'(r_k));

        mul_a = 32'sd0;
        mul_b = 32'sd0;
        unique case (r_state)
            S_SQX:     begin mul_a = 32'(r_dx); mul_b = 32'(r_dx); end
            S_SQZ:     begin mul_a = 32'(r_dz); mul_b = 32'(r_dz); end
            S_SQY:     begin mul_a = 32'(r_dy); mul_b = 32'(r_dy); end
            S_ATT_MUL: begin mul_a = 32'(r_rolloff); mul_b = 32'(r_dq); end
            G_L1:      begin mul_a = r_ca; mul_b = coef.c; end
            G_L2:      begin mul_a = r_sa; mul_b = coef.s; end
            G_P1:      begin mul_a = (r_k == KW'(1)) ? r_ca : r_sa; mul_b = r_ce; end
            G_H1:      begin mul_a = r_u; mul_b = (r_k >= KW'(8)) ? height : r_ce; end
            G_ATT:     begin mul_a = r_u; mul_b = 32'(r_att); end
            S_SMP_MUL: begin mul_a = 32'(r_sample); mul_b = 32'(r_gain[r_k]); end
            default:   begin mul_a = 32'sd0; mul_b = 32'sd0; end
        endcase

        // Speaker lobe: max(0, cos(az - a)), limited to one.
        lobe_v = rnd_shr(r_acc + r_prod, 30);
        if (lobe_v < 64'sd0) begin
            lobe_u = 32'sd0;
        end else if (lobe_v > 64'(ONE30)) begin
            lobe_u = ONE30;
        end else begin
            lobe_u = 32'(lobe_v);
        end
        p2_v = rnd_shr(r_prod, 30);
        p2_u = 32'(p2_v);

        // Stereo behind the listener pans hard to the side it sits on.
        if (r_k == KW'(0)) begin
            stereo_u = r_sa[31] ? ONE30 : 32'sd0;
        end else begin
            stereo_u = r_sa[31] ? 32'sd0 : ONE30;
        end

        gain_v = rnd_shr(r_prod, 30);
        if (gain_v > 64'sd32767) begin
            gain_wr = 16'sh7fff;
        end else if (gain_v < -64'sd32768) begin
            gain_wr = -16'sh8000;
        end else begin
            gain_wr = 16'(gain_v);
        end

        smp_v = rnd_shr(r_prod, 15);
        if (smp_v > SMP_MAX) begin
            smp_val = SAMPLE_BITS'(SMP_MAX);
        end else if (smp_v < SMP_MIN) begin
            smp_val = SAMPLE_BITS'(SMP_MIN);
        end else begin
            smp_val = SAMPLE_BITS'(smp_v);
        end

        // Square-root launch.
        st_diff = (r_k == KW'(0)) ? (64'(ONE30) - 64'(r_sa)) : (64'(ONE30) + 64'(r_sa));
        sq_go  = 1'b0;
        sq_rad = '0;
        if (r_state == S_HQ_GO) begin
            sq_go  = 1'b1;
            sq_rad = SQ_RW'(r_hsum) << 16;
        end else if (r_state == S_DQ_GO) begin
            sq_go  = 1'b1;
            sq_rad = SQ_RW'(r_dsum) << 16;
        end else if (r_state == G_START && r_lay == LAY_STEREO && !r_ca[31]) begin
            sq_go  = 1'b1;
            sq_rad = SQ_RW'(st_diff <<< 29);
        end

        // One square-root step: two radicand bits in, one root bit out.
        sq_rem2  = {r_sq_rem, r_sq_rad[SQ_RW-1 -: 2]};
        sq_trial = {2'b00, r_sq_root, 2'b01};
        if (sq_rem2 >= sq_trial) begin
            sq_rem_nx  = 33'(sq_rem2 - sq_trial);
            sq_root_nx = {r_sq_root[SQ_QW-2:0], 1'b1};
        end else begin
            sq_rem_nx  = 33'(sq_rem2);
            sq_root_nx = {r_sq_root[SQ_QW-2:0], 1'b0};
        end

        // Divider launch for the direction cosines and the attenuation.
        dv_go  = 1'b0;
        dv_neg = 1'b0;
        dv_mag = '0;
        dv_den = '0;
        if (r_state == S_DV_SETUP) begin
            unique case (r_dstep)
                D_CA: begin
                    dv_go  = (r_hq != '0) && (r_dq != '0);
                    dv_mag = DV_NW'(abs_dz) << 38;
                    dv_den = DV_DW'(r_hq);
                    dv_neg = (r_dz > 17'sd0);
                end
                D_SA: begin
                    dv_go  = 1'b1;
                    dv_mag = DV_NW'(abs_dx) << 38;
                    dv_den = DV_DW'(r_hq);
                    dv_neg = r_dx[16];
                end
                D_CE: begin
                    dv_go  = (r_dq != '0);
                    dv_mag = DV_NW'(r_hq) << 30;
                    dv_den = DV_DW'(r_dq);
                end
                D_SE: begin
                    dv_go  = 1'b1;
                    dv_mag = DV_NW'(abs_dy) << 38;
                    dv_den = DV_DW'(r_dq);
                    dv_neg = r_dy[16];
                end
                D_ATT: begin
                    dv_go  = !(r_dq > {r_maxd, 8'd0});
                    dv_mag = DV_NW'(10) << 43;
                    dv_den = (DV_DW'(10) << 28) + DV_DW'(r_prod[40:0]);
                end
                default: begin
                    dv_go = 1'b0;
                end
            endcase
        end

        // One restoring division step.
        dv_rem2 = {r_dv_rem, r_dv_num[DV_NW-1]};

        // Rounded quotient limited to one in Q2.30, then signed.
        if (r_dv_quo > DV_NW'(ONE30)) begin
            dv_qsat = ONE30;
        end else begin
            dv_qsat = 32'(r_dv_quo[30:0]);
        end
        dv_sig = r_dv_neg ? -dv_qsat : dv_qsat;
        dv_att = (r_dv_quo > DV_NW'(32767)) ? 15'h7fff : r_dv_quo[14:0];
    end

    // Shared multiplier, registered.
    always_ff @(posedge i_clk) begin
        r_prod <= 64'(mul_a) * 64'(mul_b);
    end

    // Square-root unit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_cnt <= '0;
        end else if (sq_go) begin
            r_sq_rad  <= sq_rad;
            r_sq_rem  <= '0;
            r_sq_root <= '0;
            r_sq_cnt  <= SQ_CW'(SQ_N);
        end else if (r_sq_cnt != '0) begin
            r_sq_rad  <= r_sq_rad << 2;
            r_sq_rem  <= sq_rem_nx;
            r_sq_root <= sq_root_nx;
            r_sq_cnt  <= r_sq_cnt - 1'b1;
        end
    end

    // Divider unit; the numerator already carries half the divisor.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_cnt <= '0;
        end else if (dv_go) begin
            r_dv_num <= dv_mag + DV_NW'(dv_den >> 1);
            r_dv_den <= dv_den;
            r_dv_rem <= '0;
            r_dv_quo <= '0;
            r_dv_neg <= dv_neg;
            r_dv_cnt <= DV_CW'(DV_NW);
        end else if (r_dv_cnt != '0) begin
            if (dv_rem2 >= {1'b0, r_dv_den}) begin
                r_dv_rem <= DV_DW'(dv_rem2 - {1'b0, r_dv_den});
                r_dv_quo <= {r_dv_quo[DV_NW-2:0], 1'b1};
            end else begin
                r_dv_rem <= DV_DW'(dv_rem2);
                r_dv_quo <= {r_dv_quo[DV_NW-2:0], 1'b0};
            end
            r_dv_num <= r_dv_num << 1;
            r_dv_cnt <= r_dv_cnt - 1'b1;
        end
    end

    // Sequencer with its datapath and output registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_dstep     <= D_CA;
            r_mode      <= 1'b1;
            r_layout    <= 3'd2;
            r_lx        <= '0;
            r_ly        <= '0;
            r_lz        <= '0;
            r_rolloff   <= 16'd4096;
            r_maxd      <= 17'd25600;
            r_ex        <= '0;
            r_ey        <= '0;
            r_ez        <= '0;
            r_out_valid <= 1'b0;
            r_k         <= '0;
            for (int i = 0; i < MAX_CHANNELS; i++) begin
                r_gain[i] <= '0;
            end
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_cfg.valid && cfg_rdy) begin
                        unique case (i_cfg.index)
                            CFG_MODE: begin
                                r_mode  <= i_cfg.data[0];
                                r_state <= S_DIFF;
                            end
                            CFG_LAYOUT: begin
                                r_layout <= i_cfg.data[2:0];
                                r_state  <= S_DIFF;
                            end
                            CFG_LX: begin
                                r_lx    <= i_cfg.data[15:0];
                                r_state <= S_DIFF;
                            end
                            CFG_LY: begin
                                r_ly    <= i_cfg.data[15:0];
                                r_state <= S_DIFF;
                            end
                            CFG_LZ: begin
                                r_lz    <= i_cfg.data[15:0];
                                r_state <= S_DIFF;
                            end
                            CFG_ROLLOFF: begin
                                r_rolloff <= i_cfg.data[15:0];
                                r_state   <= S_DIFF;
                            end
                            CFG_MAXDIST: begin
                                r_maxd  <= i_cfg.data;
                                r_state <= S_DIFF;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end else if (i_in.valid && in_rdy) begin
                        if (!i_in.func) begin
                            r_ex    <= i_in.pos_x;
                            r_ey    <= i_in.pos_y;
                            r_ez    <= i_in.pos_z;
                            r_state <= S_DIFF;
                        end else begin
                            r_sample <= i_in.sample_in;
                            r_k      <= '0;
                            r_n      <= chan_count(layout_of(r_mode, r_layout));
                            r_state  <= S_SMP_MUL;
                        end
                    end
                end

                // Emitter minus listener; direction defaults for a zero vector.
                S_DIFF: begin
                    r_dx    <= 17'(r_ex) - 17'(r_lx);
                    r_dy    <= 17'(r_ey) - 17'(r_ly);
                    r_dz    <= 17'(r_ez) - 17'(r_lz);
                    r_ca    <= ONE30;
                    r_sa    <= 32'sd0;
                    r_ce    <= ONE30;
                    r_se    <= 32'sd0;
                    r_lay   <= layout_of(r_mode, r_layout);
                    r_n     <= chan_count(layout_of(r_mode, r_layout));
                    r_k     <= '0;
                    r_dstep <= D_CA;
                    for (int i = 0; i < MAX_CHANNELS; i++) begin
                        r_gain[i] <= '0;
                    end
                    r_state <= S_SQX;
                end

                // Squared horizontal and full distances.
                S_SQX: r_state <= S_SQZ;
                S_SQZ: begin
                    r_hsum  <= 34'(r_prod);
                    r_state <= S_SQY;
                end
                S_SQY: begin
                    r_hsum  <= r_hsum + 34'(r_prod);
                    r_state <= S_SQD;
                end
                S_SQD: begin
                    r_dsum  <= r_hsum + 34'(r_prod);
                    r_state <= S_HQ_GO;
                end

                S_HQ_GO: r_state <= S_HQ_WAIT;
                S_HQ_WAIT: begin
                    if (r_sq_cnt == '0) begin
                        r_hq    <= r_sq_root[24:0];
                        r_state <= S_DQ_GO;
                    end
                end
                S_DQ_GO: r_state <= S_DQ_WAIT;
                S_DQ_WAIT: begin
                    if (r_sq_cnt == '0) begin
                        r_dq    <= r_sq_root[24:0];
                        r_state <= S_DV_SETUP;
                    end
                end

                // Launch the next quotient or skip it at zero or over-max distance.
                S_DV_SETUP: begin
                    if (dv_go) begin
                        r_state <= S_DV_WAIT;
                    end else begin
                        unique case (r_dstep)
                            D_CA: begin
                                if (r_dq != '0) begin
                                    r_dstep <= D_CE;
                                end else begin
                                    r_state <= S_ATT_MUL;
                                end
                            end
                            D_CE: r_state <= S_ATT_MUL;
                            D_ATT: begin
                                r_att   <= '0;
                                r_state <= G_START;
                            end
                            default: r_state <= S_ATT_MUL;
                        endcase
                    end
                end

                S_DV_WAIT: begin
                    if (r_dv_cnt == '0) begin
                        unique case (r_dstep)
                            D_CA: begin
                                r_ca    <= dv_sig;
                                r_dstep <= D_SA;
                                r_state <= S_DV_SETUP;
                            end
                            D_SA: begin
                                r_sa    <= dv_sig;
                                r_dstep <= D_CE;
                                r_state <= S_DV_SETUP;
                            end
                            D_CE: begin
                                r_ce    <= dv_sig;
                                r_dstep <= D_SE;
                                r_state <= S_DV_SETUP;
                            end
                            D_SE: begin
                                r_se    <= dv_sig;
                                r_state <= S_ATT_MUL;
                            end
                            D_ATT: begin
                                r_att   <= dv_att;
                                r_state <= G_START;
                            end
                            default: r_state <= G_START;
                        endcase
                    end
                end

                // rolloff * distance for the attenuation divisor.
                S_ATT_MUL: begin
                    r_dstep <= D_ATT;
                    r_state <= S_DV_SETUP;
                end

                // Pick how the unattenuated gain of channel k is formed.
                G_START: begin
                    unique case (r_lay)
                        LAY_AMBI: begin
                            if (r_k == KW'(0)) begin
                                r_u     <= S45;
                                r_state <= G_ATT;
                            end else if (r_k == KW'(3)) begin
                                r_u     <= r_se;
                                r_state <= G_ATT;
                            end else begin
                                r_state <= G_P1;
                            end
                        end
                        LAY_STEREO: begin
                            if (!r_ca[31]) begin
                                r_state <= G_SQW;
                            end else begin
                                r_u     <= stereo_u;
                                r_state <= G_ATT;
                            end
                        end
                        LAY_SURR: begin
                            if (r_k == KW'(3)) begin
                                r_u     <= HALF30;
                                r_state <= G_ATT;
                            end else begin
                                r_state <= G_L1;
                            end
                        end
                        default: r_state <= G_L1;
                    endcase
                end

                G_L1: r_state <= G_L2;
                G_L2: begin
                    r_acc   <= r_prod;
                    r_state <= G_L3;
                end
                G_L3: begin
                    r_u     <= lobe_u;
                    r_state <= (r_lay == LAY_714) ? G_H1 : G_ATT;
                end
                G_P1: r_state <= G_P2;
                G_H1: r_state <= G_P2;
                G_P2: begin
                    r_u     <= p2_u;
                    r_state <= G_ATT;
                end
                G_SQW: begin
                    if (r_sq_cnt == '0) begin
                        r_u     <= 32'(r_sq_root);
                        r_state <= G_ATT;
                    end
                end
                G_ATT: r_state <= G_WR;
                G_WR: begin
                    r_gain[r_k] <= gain_wr;
                    if (k_last) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= G_START;
                    end
                end

                // One scaled sample per channel.
                S_SMP_MUL: r_state <= S_SMP_OUT;
                S_SMP_OUT: begin
                    r_out_valid <= 1'b1;
                    r_out_ch    <= CH_W'(r_k);
                    r_out_smp   <= smp_val;
                    r_out_last  <= k_last;
                    r_state     <= S_SMP_WAIT;
                end
                S_SMP_WAIT: begin
                    if (o_out.ready) begin
                        r_out_valid <= 1'b0;
                        if (r_out_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_k     <= r_k + 1'b1;
                            r_state <= S_SMP_MUL;
                        end
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire
